// ===== rtl/egcd_pkg.sv =====
`timescale 1ns / 1ps

package egcd_pkg;

    // Operand and result width, fixed by the request and result formats
    localparam int DATA_W = 32;
    // Step counter width, enough to index one quotient bit per cycle
    localparam int CNT_W = $clog2(DATA_W);

    typedef logic [DATA_W-1:0] word_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] first_value;
        logic signed [DATA_W-1:0] second_value;
    } request_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] divisor;
        logic signed [DATA_W-1:0] coeff_first;
        logic signed [DATA_W-1:0] coeff_second;
    } result_t;

    // Control shared by the serial divider and the coefficient accumulator
    typedef struct packed {
        logic load;
        logic step;
    } step_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_STEP,
        ST_FINISH,
        ST_DONE
    } state_t;

    // Absolute value of a two's complement word, as an unsigned word
    function automatic word_t magnitude(input word_t v);
        word_t m;
        m = v[DATA_W-1] ? (~v + word_t'(1)) : v;
        return m;
    endfunction

endpackage

// ===== rtl/extended_gcd_coefficients.sv =====
`timescale 1ns / 1ps

// Extended Euclid engine: for a request (first_value, second_value) it returns
// one result (divisor, coeff_first, coeff_second) with
// first_value*coeff_first + second_value*coeff_second == divisor, using
// truncating division, so divisor may be negative for negative operands; a zero
// first_value gives (second_value, 0, 1). One request is worked at a time and
// request_stall stays high until its result has been taken. Each Euclid round
// runs the serial divider, one quotient bit per cycle, with both coefficient
// products built from the same bits; the ST_FINISH state then updates the
// operands and coefficients and either starts the next round or registers
// the result. A request takes at most about 46 rounds for 32-bit operands.
module extended_gcd_coefficients (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                request_valid,
    output logic                request_stall,
    input  egcd_pkg::request_t  request,
    output logic                result_valid,
    input  logic                result_stall,
    output egcd_pkg::result_t   result
);

    egcd_pkg::state_t           state_reg;
    egcd_pkg::state_t           state_next;
    logic [egcd_pkg::CNT_W-1:0] cnt_reg;
    egcd_pkg::word_t            a_reg;
    egcd_pkg::word_t            b_reg;
    egcd_pkg::word_t            xp_reg;
    egcd_pkg::word_t            xc_reg;
    egcd_pkg::word_t            yp_reg;
    egcd_pkg::word_t            yc_reg;
    egcd_pkg::result_t          result_reg;

    egcd_pkg::step_ctrl_t       ctrl;
    egcd_pkg::word_t            div_num;
    egcd_pkg::word_t            div_den;
    logic                       quot_bit;
    egcd_pkg::word_t            rem_mag;
    egcd_pkg::word_t            prod_x;
    egcd_pkg::word_t            prod_y;
    egcd_pkg::word_t            rem_signed;
    logic                       quot_neg;
    logic                       accept;

    assign accept = request_valid && !request_stall;

    // Remainder takes the dividend sign; quotient is negative on differing signs
    always_comb
    begin
        rem_signed = b_reg[egcd_pkg::DATA_W-1] ? (~rem_mag + egcd_pkg::word_t'(1))
                                               : rem_mag;
        quot_neg   = a_reg[egcd_pkg::DATA_W-1] ^ b_reg[egcd_pkg::DATA_W-1];
    end

    // Divider operands: fresh pair after a request, rotated pair after a round
    always_comb
    begin
        if (state_reg == egcd_pkg::ST_FINISH)
        begin
            div_num = egcd_pkg::magnitude(a_reg);
            div_den = rem_mag;
        end
        else
        begin
            div_num = egcd_pkg::magnitude(b_reg);
            div_den = egcd_pkg::magnitude(a_reg);
        end
    end

    egcd_div u_div (
        .clk      (clk),
        .ctrl     (ctrl),
        .num_mag  (div_num),
        .den_mag  (div_den),
        .quot_bit (quot_bit),
        .rem_mag  (rem_mag)
    );

    egcd_macc u_macc (
        .clk      (clk),
        .ctrl     (ctrl),
        .quot_bit (quot_bit),
        .coeff_x  (xc_reg),
        .coeff_y  (yc_reg),
        .prod_x   (prod_x),
        .prod_y   (prod_y)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            egcd_pkg::ST_IDLE:
            begin
                if (request_valid)
                    state_next = egcd_pkg::ST_CHECK;
            end
            egcd_pkg::ST_CHECK:
            begin
                state_next = (a_reg == '0) ? egcd_pkg::ST_DONE : egcd_pkg::ST_STEP;
            end
            egcd_pkg::ST_STEP:
            begin
                if (cnt_reg == '0)
                    state_next = egcd_pkg::ST_FINISH;
            end
            egcd_pkg::ST_FINISH:
            begin
                state_next = (rem_mag == '0) ? egcd_pkg::ST_DONE : egcd_pkg::ST_STEP;
            end
            egcd_pkg::ST_DONE:
            begin
                if (!result_stall)
                    state_next = egcd_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = egcd_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        ctrl          = '0;
        request_stall = 1'b1;
        result_valid  = 1'b0;
        unique case (state_reg)
            egcd_pkg::ST_IDLE:
            begin
                request_stall = 1'b0;
            end
            egcd_pkg::ST_CHECK:
            begin
                ctrl.load = (a_reg != '0);
            end
            egcd_pkg::ST_STEP:
            begin
                ctrl.step = 1'b1;
            end
            egcd_pkg::ST_FINISH:
            begin
                ctrl.load = (rem_mag != '0);
            end
            egcd_pkg::ST_DONE:
            begin
                result_valid = 1'b1;
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

    assign result = result_reg;

    // Hold the sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= egcd_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Step counter: reload on divider load, count down while stepping
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
            cnt_reg <= egcd_pkg::CNT_W'(egcd_pkg::DATA_W - 1);
        else if (ctrl.step)
            cnt_reg <= cnt_reg - egcd_pkg::CNT_W'(1);
    end

    // Operands, coefficients and the result register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_reg  <= request.first_value;
            b_reg  <= request.second_value;
            xp_reg <= '0;
            xc_reg <= egcd_pkg::word_t'(1);
            yp_reg <= egcd_pkg::word_t'(1);
            yc_reg <= '0;
        end
        else if (state_reg == egcd_pkg::ST_CHECK && a_reg == '0)
        begin
            result_reg.divisor      <= b_reg;
            result_reg.coeff_first  <= xp_reg;
            result_reg.coeff_second <= yp_reg;
        end
        else if (state_reg == egcd_pkg::ST_FINISH)
        begin
            a_reg  <= rem_signed;
            b_reg  <= a_reg;
            xp_reg <= xc_reg;
            xc_reg <= quot_neg ? (xp_reg + prod_x) : (xp_reg - prod_x);
            yp_reg <= yc_reg;
            yc_reg <= quot_neg ? (yp_reg + prod_y) : (yp_reg - prod_y);
            if (rem_mag == '0)
            begin
                result_reg.divisor      <= a_reg;
                result_reg.coeff_first  <= xc_reg;
                result_reg.coeff_second <= yc_reg;
            end
        end
    end

endmodule

// ===== rtl/egcd_div.sv =====
`timescale 1ns / 1ps

// Restoring divider on magnitudes: one quotient bit per step, MSB first.
module egcd_div (
    input  logic                  clk,
    input  egcd_pkg::step_ctrl_t  ctrl,
    input  egcd_pkg::word_t       num_mag,
    input  egcd_pkg::word_t       den_mag,
    output logic                  quot_bit,
    output egcd_pkg::word_t       rem_mag
);

    egcd_pkg::word_t            rem_reg;
    egcd_pkg::word_t            dvd_reg;
    egcd_pkg::word_t            den_reg;
    logic [egcd_pkg::DATA_W:0]  trial;
    logic [egcd_pkg::DATA_W:0]  trial_diff;

    // Shift in the next dividend bit and try the subtract
    always_comb
    begin
        trial      = {rem_reg, dvd_reg[egcd_pkg::DATA_W-1]};
        trial_diff = trial - {1'b0, den_reg};
        quot_bit   = (trial >= {1'b0, den_reg});
    end

    assign rem_mag = rem_reg;

    // Load operands, then advance one bit per step
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            rem_reg <= '0;
            dvd_reg <= num_mag;
            den_reg <= den_mag;
        end
        else if (ctrl.step)
        begin
            rem_reg <= quot_bit ? trial_diff[egcd_pkg::DATA_W-1:0]
                                : trial[egcd_pkg::DATA_W-1:0];
            dvd_reg <= {dvd_reg[egcd_pkg::DATA_W-2:0], 1'b0};
        end
    end

endmodule

// ===== rtl/egcd_macc.sv =====
`timescale 1ns / 1ps

// Shift-add products of the quotient magnitude with both current
// coefficients, fed one quotient bit per step, MSB first, modulo 2^DATA_W.
module egcd_macc (
    input  logic                  clk,
    input  egcd_pkg::step_ctrl_t  ctrl,
    input  logic                  quot_bit,
    input  egcd_pkg::word_t       coeff_x,
    input  egcd_pkg::word_t       coeff_y,
    output egcd_pkg::word_t       prod_x,
    output egcd_pkg::word_t       prod_y
);

    egcd_pkg::word_t acc_x_reg;
    egcd_pkg::word_t acc_y_reg;

    assign prod_x = acc_x_reg;
    assign prod_y = acc_y_reg;

    // Clear on load, then double and add the coefficient on a set bit
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            acc_x_reg <= '0;
            acc_y_reg <= '0;
        end
        else if (ctrl.step)
        begin
            acc_x_reg <= {acc_x_reg[egcd_pkg::DATA_W-2:0], 1'b0}
                         + (quot_bit ? coeff_x : '0);
            acc_y_reg <= {acc_y_reg[egcd_pkg::DATA_W-2:0], 1'b0}
                         + (quot_bit ? coeff_y : '0);
        end
    end

endmodule
